/* sv/mrpt_pkg.sv */
`timescale 1ns / 1ps
package mrpt_pkg;

  localparam int WORD_W         = 64;
  localparam int CNT_W          = $clog2(WORD_W + 1);
  localparam int K_W            = $clog2(WORD_W);
  localparam int BASE_TABLE_LEN = 12;
  localparam int IDX_W          = $clog2(BASE_TABLE_LEN + 1);
  localparam int BASE_W         = 6;
  localparam int NUM_BASES_DEF  = 12;

  // Fixed witness bases, the first twelve primes.
  function automatic logic [BASE_W-1:0] base_of(input logic [IDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    unique case (idx)
      IDX_W'(0):  b = BASE_W'(2);
      IDX_W'(1):  b = BASE_W'(3);
      IDX_W'(2):  b = BASE_W'(5);
      IDX_W'(3):  b = BASE_W'(7);
      IDX_W'(4):  b = BASE_W'(11);
      IDX_W'(5):  b = BASE_W'(13);
      IDX_W'(6):  b = BASE_W'(17);
      IDX_W'(7):  b = BASE_W'(19);
      IDX_W'(8):  b = BASE_W'(23);
      IDX_W'(9):  b = BASE_W'(29);
      IDX_W'(10): b = BASE_W'(31);
      IDX_W'(11): b = BASE_W'(37);
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

/* sv/mrpt_in_if.sv */
`timescale 1ns / 1ps
interface mrpt_in_if import mrpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] n_value;

  modport source (output valid, output n_value, input ready);
  modport sink (input valid, input n_value, output ready);
endinterface

/* sv/mrpt_out_if.sv */
`timescale 1ns / 1ps
interface mrpt_out_if import mrpt_pkg::*; ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

/* sv/mrpt_mulmod.sv */
`timescale 1ns / 1ps
module mrpt_mulmod import mrpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] m,
  output logic              done,
  output logic [WORD_W-1:0] prod
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_DBL,
    M_ADD
  } mstate_t;

  mstate_t           state;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] xa;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] mr;
  logic [CNT_W-1:0]  cnt;

  // Shared mod adder: operands are both below m, so one conditional subtract.
  logic [WORD_W-1:0] op_b;
  logic [WORD_W:0]   sum;
  logic [WORD_W+1:0] dif;
  logic [WORD_W-1:0] red;

  assign op_b = (state == M_ADD) ? xa : acc;
  assign sum  = {1'b0, acc} + {1'b0, op_b};
  assign dif  = {1'b0, sum} - {2'b00, mr};
  assign red  = dif[WORD_W+1] ? sum[WORD_W-1:0] : dif[WORD_W-1:0];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            acc   <= '0;
            xa    <= a;
            y     <= b;
            mr    <= m;
            cnt   <= CNT_W'(WORD_W);
            state <= M_DBL;
          end
        end
        M_DBL: begin
          acc <= red;
          if (y[WORD_W-1]) begin
            state <= M_ADD;
          end else begin
            y   <= y << 1;
            cnt <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= M_IDLE;
              done  <= 1'b1;
            end
          end
        end
        M_ADD: begin
          acc   <= red;
          y     <= y << 1;
          cnt   <= cnt - CNT_W'(1);
          state <= M_DBL;
          if (cnt == CNT_W'(1)) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* sv/miller_rabin_prime_test_64_unit.sv */
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test for 64-bit unsigned values.
//
// in_ch carries one n_value per beat; out_ch returns one is_prime bit per
// input beat (1 = prime, 0 = composite), in order. Bases are the first
// NUM_BASES primes from 2 to 37; all twelve are exact for any 64-bit input.
//
// One item at a time: in_ch.ready is high only while the sequencer idles.
// Zero, one and even values above two go straight to the done state. Other
// values first strip trailing zeros of n-1, then run each base through
// square-and-multiply. Every modular product goes through one shared
// double-and-add unit: a doubling step for every multiplier bit plus an add
// step for each set multiplier bit. A base costs at most about 126 products.
//
// The result sits in an output register; the next item is accepted while
// it waits. A finished item holds in the done state if the previous result
// was not yet taken. Synchronous reset returns to idle and drops any
// pending result; no table or memory needs clearing.
module miller_rabin_prime_test_64_unit import mrpt_pkg::*; #(
  parameter int NUM_BASES = NUM_BASES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mrpt_in_if.sink     in_ch,
  mrpt_out_if.source  out_ch
);

  // Bases beyond the table act as the full table.
  localparam int USED_BASES = (NUM_BASES > BASE_TABLE_LEN) ? BASE_TABLE_LEN : NUM_BASES;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACTOR,
    S_BASE,
    S_POW,
    S_W_ACC,
    S_SHIFT,
    S_W_X,
    S_CHK,
    S_SQLOOP,
    S_W_SQ,
    S_DONE
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] nr;
  logic [WORD_W-1:0] nm1;
  logic [WORD_W-1:0] q;
  logic [K_W-1:0]    k;
  logic [K_W-1:0]    j;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] xr;
  logic [WORD_W-1:0] e;
  logic              res;
  logic              out_valid;
  logic              out_prime;

  // Product unit handshake.
  logic              mm_start;
  logic [WORD_W-1:0] mm_a;
  logic [WORD_W-1:0] mm_b;
  logic              mm_done;
  logic [WORD_W-1:0] mm_prod;

  logic [WORD_W-1:0] base_w;
  logic [WORD_W-1:0] e_shr;

  assign base_w = {{(WORD_W-BASE_W){1'b0}}, base_of(idx)};
  assign e_shr  = e >> 1;

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.is_prime = out_prime;

  mrpt_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (nr),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mm_start  <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      // Drop the result once the receiver takes the beat.
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            nr  <= in_ch.n_value;
            nm1 <= in_ch.n_value - WORD_W'(1);
            q   <= in_ch.n_value - WORD_W'(1);
            k   <= '0;
            if ((in_ch.n_value < WORD_W'(2)) ||
                ((in_ch.n_value > WORD_W'(2)) && !in_ch.n_value[0])) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_FACTOR;
            end
          end
        end
        S_FACTOR: begin
          // Strip trailing zeros: n-1 = q * 2^k.
          if ((q != '0) && !q[0]) begin
            q <= q >> 1;
            k <= k + K_W'(1);
          end else begin
            idx   <= '0;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          if (idx == IDX_W'(USED_BASES)) begin
            res   <= 1'b1;
            state <= S_DONE;
          end else if (base_w >= nm1) begin
            idx <= idx + IDX_W'(1);
          end else begin
            acc   <= WORD_W'(1);
            xr    <= base_w;
            e     <= q;
            state <= S_POW;
          end
        end
        S_POW: begin
          if (e == '0) begin
            state <= S_CHK;
          end else if (e[0]) begin
            mm_a     <= acc;
            mm_b     <= xr;
            mm_start <= 1'b1;
            state    <= S_W_ACC;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_W_ACC: begin
          if (mm_done) begin
            acc   <= mm_prod;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // Advance the exponent; skip the square after the last bit.
          e <= e_shr;
          if (e_shr != '0) begin
            mm_a     <= xr;
            mm_b     <= xr;
            mm_start <= 1'b1;
            state    <= S_W_X;
          end else begin
            state <= S_CHK;
          end
        end
        S_W_X: begin
          if (mm_done) begin
            xr    <= mm_prod;
            state <= S_POW;
          end
        end
        S_CHK: begin
          if (acc == WORD_W'(1)) begin
            idx   <= idx + IDX_W'(1);
            state <= S_BASE;
          end else begin
            j     <= '0;
            state <= S_SQLOOP;
          end
        end
        S_SQLOOP: begin
          if (j == k) begin
            res   <= 1'b0;
            state <= S_DONE;
          end else if (acc == nm1) begin
            idx   <= idx + IDX_W'(1);
            state <= S_BASE;
          end else begin
            mm_a     <= acc;
            mm_b     <= acc;
            mm_start <= 1'b1;
            j        <= j + K_W'(1);
            state    <= S_W_SQ;
          end
        end
        S_W_SQ: begin
          if (mm_done) begin
            acc   <= mm_prod;
            state <= S_SQLOOP;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_prime <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_miller_rabin_prime_test_64_unit.sv */
`timescale 1ns / 1ps
module tb_miller_rabin_prime_test_64_unit;
  import mrpt_pkg::*;

  typedef logic [WORD_W-1:0] word_t;

  // Accepted value paired with the verdict it must produce.
  typedef struct packed {
    word_t n;
    logic  is_prime;
  } verdict_t;

  localparam int NUM_WITNESS = NUM_BASES_DEF;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mrpt_in_if  in_ch ();
  mrpt_out_if out_ch ();

  miller_rabin_prime_test_64_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t    n_pending_q [$];
  verdict_t verdict_q [$];

  int n_total = 0;
  int beats_in = 0;
  int beats_out = 0;
  int primes_seen = 0;
  int errors = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Golden verdict: Miller-Rabin with the first twelve primes as witnesses.
  // Products are taken at full 128-bit width and reduced once, which gives the
  // same residues as the block's double-and-add unit without its loop.
  // ---------------------------------------------------------------------------
  function automatic word_t witness_base(input int idx);
    word_t b;
    case (idx)
      0:       b = 2;
      1:       b = 3;
      2:       b = 5;
      3:       b = 7;
      4:       b = 11;
      5:       b = 13;
      6:       b = 17;
      7:       b = 19;
      8:       b = 23;
      9:       b = 29;
      10:      b = 31;
      default: b = 37;
    endcase
    return b;
  endfunction

  function automatic word_t mulmod(input word_t a, input word_t b, input word_t m);
    logic [2*WORD_W-1:0] p;
    p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    return word_t'(p % {{WORD_W{1'b0}}, m});
  endfunction

  // Only called with m > 2, so the starting accumulator 1 is already reduced.
  function automatic word_t powmod(input word_t b, input word_t e, input word_t m);
    word_t acc;
    word_t sq;
    word_t ex;
    acc = 1;
    sq  = b % m;
    ex  = e;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, sq, m);
      ex = ex >> 1;
      sq = mulmod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic logic prime_verdict(input word_t n);
    word_t q;
    word_t x;
    int    k;
    int    i;
    int    j;
    logic  witness_ok;
    if (n < 2) return 1'b0;
    if (n > 2 && !n[0]) return 1'b0;
    // Split n-1 into an odd part and a power of two.
    q = n - 1;
    k = 0;
    while (q != 0 && !q[0]) begin
      q = q >> 1;
      k++;
    end
    for (i = 0; i < NUM_WITNESS; i++) begin
      // A witness at or beyond n-1 says nothing; skip it.
      if (witness_base(i) >= n - 1) continue;
      x = powmod(witness_base(i), q, n);
      if (x == 1) continue;
      witness_ok = 1'b0;
      for (j = 0; j < k; j++) begin
        if (x == n - 1) begin
          witness_ok = 1'b1;
          break;
        end
        x = mulmod(x, x, n);
      end
      if (!witness_ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values. Run time grows with the bit length of n, so keep most values
  // at 16 bits and only a few at full width. Odd values get past the parity
  // check into the witness loop; a share is pushed to the next prime so that
  // every witness runs to the end.
  // ---------------------------------------------------------------------------
  function automatic word_t pick_random_n();
    word_t n;
    word_t a;
    word_t b;
    int    sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      n = word_t'($urandom_range(16'hffff)) | 1;
    end else if (sel < 52) begin
      n = word_t'($urandom_range(16'hffff)) | 1;
      while (!prime_verdict(n)) n = n + 2;
    end else if (sel < 64) begin
      n = word_t'($urandom_range(16'hffff));
    end else if (sel < 76) begin
      // Odd composite with no factor below three.
      a = word_t'($urandom_range(16'hffff, 3)) | 1;
      b = word_t'($urandom_range(16'hffff, 3)) | 1;
      n = a * b;
    end else if (sel < 88) begin
      n = word_t'($urandom) | 1;
    end else begin
      n = {$urandom, $urandom};
    end
    return n;
  endfunction

  // Pacing: sender idles 32% and receiver 82% over the first third of beats,
  // then the reverse, then neither idles for the last third.
  function automatic int send_idle_pct();
    if (beats_in * 3 < n_total) return 32;
    if (beats_in * 3 < n_total * 2) return 82;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (beats_in * 3 < n_total) return 82;
    if (beats_in * 3 < n_total * 2) return 32;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: once the current beat is gone, present the next pending value unless the sender idles.
  // valid gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.n_value <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (n_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_ch.valid   <= 1'b1;
        in_ch.n_value <= n_pending_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: record the verdict for each accepted value, then check each
  // returned beat against the oldest one. Input is handled first so that a
  // value taken on the same edge as a result lands behind it in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        exp_v.n        = in_ch.n_value;
        exp_v.is_prime = prime_verdict(in_ch.n_value);
        verdict_q.push_back(exp_v);
        beats_in++;
        if (exp_v.is_prime) primes_seen++;
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_out++;
        if (verdict_q.size() == 0) begin
          $error("unexpected result beat: is_prime=%0b with no value outstanding",
                 out_ch.is_prime);
          errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_ch.is_prime !== exp_v.is_prime) begin
            $error("is_prime for n=%0d: expected %0b, actual %0b",
                   exp_v.n, exp_v.is_prime, out_ch.is_prime);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    in_ch.valid   = 1'b0;
    in_ch.n_value = '0;
    out_ch.ready  = 1'b0;

    // Directed: trivial values, parity, witness skipping, strong pseudoprimes
    // that fool successively longer witness prefixes, and the field extremes.
    n_pending_q.push_back(64'd0);
    n_pending_q.push_back(64'd1);
    n_pending_q.push_back(64'd2);
    n_pending_q.push_back(64'd3);
    n_pending_q.push_back(64'd4);
    n_pending_q.push_back(64'd5);
    n_pending_q.push_back(64'd9);
    n_pending_q.push_back(64'd37);
    n_pending_q.push_back(64'd38);
    n_pending_q.push_back(64'd39);
    n_pending_q.push_back(64'd41);
    n_pending_q.push_back(64'd561);
    n_pending_q.push_back(64'd2047);
    n_pending_q.push_back(64'd1373653);
    n_pending_q.push_back(64'd25326001);
    n_pending_q.push_back(64'd3215031751);
    n_pending_q.push_back(64'd2152302898747);
    n_pending_q.push_back(64'd3825123056546413051);
    n_pending_q.push_back(64'd65521);
    n_pending_q.push_back(64'd4294967291);
    n_pending_q.push_back(64'h8000_0000_0000_0000);
    n_pending_q.push_back(64'hffff_ffff_ffff_fffe);
    n_pending_q.push_back(64'hffff_ffff_ffff_ffff);
    n_pending_q.push_back(64'hffff_ffff_ffff_ffc5);

    for (i = 0; i < 76; i++) n_pending_q.push_back(pick_random_n());
    n_total = n_pending_q.size();

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (beats_in < n_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    // Give any stray result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d values checked, %0d prime and %0d composite, %0d result beats",
             beats_in, primes_seen, beats_in - primes_seen, beats_out);
    $display("tb: pacing covered sender-heavy idle, receiver-heavy idle and full rate");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout for a hung run, set above the worst case even if every value were
  // prime: ~12 full-width values, ~10 at 32 bits and ~70 small ones, with the
  // longest runs on the widest values. Allow more than ten times the worst case.
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
sv/mrpt_pkg.sv
sv/mrpt_in_if.sv
sv/mrpt_out_if.sv
sv/mrpt_mulmod.sv
sv/miller_rabin_prime_test_64_unit.sv
bench/tb_miller_rabin_prime_test_64_unit.sv
